/* hdl/ppg_pkg.sv */
// Plasma pixel generator: shared types, sine quarter tables and palette function.
// No dependencies.
package ppg_pkg;

	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = 8;
	localparam int SUM_W     = 10;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef enum logic [1:0] {
		SEG_RED_GREEN  = 2'd0,
		SEG_GREEN_BLUE = 2'd1,
		SEG_BLUE_FADE  = 2'd2,
		SEG_RED_RISE   = 2'd3
	} pal_seg_t;

	localparam logic [6:0] RISE_Q [65] = '{
		7'd0,   7'd2,   7'd5,   7'd8,   7'd11,  7'd15,  7'd18,  7'd21,  7'd24,  7'd27,
		7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd56,
		7'd59,  7'd62,  7'd65,  7'd67,  7'd70,  7'd72,  7'd75,  7'd77,  7'd80,  7'd82,
		7'd85,  7'd87,  7'd89,  7'd91,  7'd93,  7'd96,  7'd98,  7'd100, 7'd101, 7'd103,
		7'd105, 7'd107, 7'd108, 7'd110, 7'd111, 7'd113, 7'd114, 7'd116, 7'd117, 7'd118,
		7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126,
		7'd126, 7'd126, 7'd126, 7'd126, 7'd127
	};

	localparam logic [7:0] FALL_Q [65] = '{
		8'd0,   8'd3,   8'd6,   8'd9,   8'd12,  8'd16,  8'd19,  8'd22,  8'd25,  8'd28,
		8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,  8'd49,  8'd52,  8'd55,  8'd57,
		8'd60,  8'd63,  8'd66,  8'd68,  8'd71,  8'd73,  8'd76,  8'd78,  8'd81,  8'd83,
		8'd86,  8'd88,  8'd90,  8'd92,  8'd94,  8'd97,  8'd99,  8'd101, 8'd102, 8'd104,
		8'd106, 8'd108, 8'd109, 8'd111, 8'd112, 8'd114, 8'd115, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd124, 8'd125, 8'd126, 8'd126, 8'd127,
		8'd127, 8'd127, 8'd127, 8'd127, 8'd128
	};

	function automatic logic signed [7:0] sine_val(input logic [7:0] i);
		logic [7:0] k;
		logic signed [8:0] mag;
		logic signed [8:0] neg;
		logic signed [7:0] res;
		if (i <= 8'd128) begin
			k   = (i <= 8'd64) ? i : 8'd128 - i;
			res = signed'({1'b0, RISE_Q[k[6:0]]});
		end else begin
			k = i - 8'd128;
			if (k > 8'd64) begin
				k = 8'd128 - k;
			end
			mag = signed'({1'b0, FALL_Q[k[6:0]]});
			neg = -mag;
			res = neg[7:0];
		end
		return res;
	endfunction

	function automatic rgb_t palette_entry(input logic [7:0] p);
		logic [7:0] t2;
		rgb_t c;
		t2 = {p[5:0], 1'b0};
		case (pal_seg_t'(p[7:6]))
			SEG_RED_GREEN: begin
				c.r = 8'd255 - t2; c.g = 8'd127 + t2; c.b = 8'd0;
			end
			SEG_GREEN_BLUE: begin
				c.r = 8'd127 - t2; c.g = 8'd255 - t2; c.b = t2;
			end
			SEG_BLUE_FADE: begin
				c.r = t2;          c.g = 8'd127 - t2; c.b = 8'd127 - t2;
			end
			SEG_RED_RISE: begin
				c.r = 8'd127 + t2; c.g = t2;          c.b = 8'd0;
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

endpackage

/* hdl/ppg_pix_if.sv */
// Input channel: pixel coordinate and frame number, valid/ready.
// No dependencies.
interface ppg_pix_if;
	logic        valid;
	logic        ready;
	logic [8:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [15:0] frame_count;

	modport source (output valid, pixel_x, pixel_y, frame_count, input ready);
	modport sink   (input valid, pixel_x, pixel_y, frame_count, output ready);
endinterface

/* hdl/ppg_rgb_if.sv */
// Output channel: palette color and index, valid/ready.
// No dependencies.
interface ppg_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] palette_index;

	modport source (output valid, red, green, blue, palette_index, input ready);
	modport sink   (input valid, red, green, blue, palette_index, output ready);
endinterface

/* hdl/plasma_pixel_generator.sv */
// Plasma pixel generator top level: index stage, palette RAM and output stage.
// Depends on ppg_pkg, ppg_pix_if, ppg_rgb_if, ppg_ram, ppg_phase_sum.
//
// One pixel beat in, one color beat out, one pixel per clock sustained
// while the color side does not stall: the sine sum is registered in the
// first stage and the palette is a 256 x 24 RAM with one registered read
// port, read once per pixel in the second stage, whose register is the
// output. After reset the palette RAM is loaded in a 256-entry sweep;
// pixel.ready stays low until it ends. Backpressure on the color side
// stalls both stages while the first stage still takes a beat if it is empty.
module plasma_pixel_generator (
	input  logic     clk,
	input  logic     arst_n,
	ppg_pix_if.sink  pixel,
	ppg_rgb_if.source color
);

	logic [ppg_pkg::PAL_AW:0]   fill_q;
	logic                       fill_done;
	logic [ppg_pkg::PAL_AW-1:0] fill_addr;
	ppg_pkg::rgb_t              fill_data;

	logic                       valid_s1;
	logic [7:0]                 idx_s1;
	logic                       valid_s2;
	logic [7:0]                 idx_s2;
	logic [7:0]                 idx_next;
	ppg_pkg::rgb_t              rgb_s2;

	logic                       adv_s2;
	logic                       adv_s1;
	logic                       take;

	assign fill_done = fill_q[ppg_pkg::PAL_AW];
	assign fill_addr = fill_q[ppg_pkg::PAL_AW-1:0];
	assign fill_data = ppg_pkg::palette_entry(fill_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (!fill_done) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	assign adv_s2      = !valid_s2 || color.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign pixel.ready = fill_done && adv_s1;
	assign take        = pixel.valid && pixel.ready;

	ppg_phase_sum u_sum (
		.pixel_x     (pixel.pixel_x),
		.pixel_y     (pixel.pixel_y),
		.frame_count (pixel.frame_count),
		.pal_idx     (idx_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= take;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_s1 <= idx_next;
		end
		if (adv_s2) begin
			idx_s2 <= idx_s1;
		end
	end

	ppg_ram #(
		.WIDTH ($bits(ppg_pkg::rgb_t)),
		.DEPTH (ppg_pkg::PAL_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (!fill_done),
		.waddr (fill_addr),
		.wdata (fill_data),
		.re    (adv_s2),
		.raddr (idx_s1),
		.rdata (rgb_s2)
	);

	assign color.valid         = valid_s2;
	assign color.red           = rgb_s2.r;
	assign color.green         = rgb_s2.g;
	assign color.blue          = rgb_s2.b;
	assign color.palette_index = idx_s2;

	a_no_beat_during_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_done |-> !pixel.ready && !valid_s1 && !valid_s2)
		else $error("pixel pipeline active during palette load");

	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted pixel beat not captured in stage 1");

	a_color_matches_index: assert property (@(posedge clk) disable iff (!arst_n)
		color.valid |-> rgb_s2 == ppg_pkg::palette_entry(idx_s2))
		else $error("palette RAM data does not match palette index");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(idx_s1))
		else $error("stage 1 beat lost under output stall");

endmodule

/* hdl/ppg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/ppg_phase_sum.sv */
// Four-term sine sum and palette index for one pixel.
// Depends on ppg_pkg.
module ppg_phase_sum (
	input  logic [8:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [15:0] frame_count,
	output logic [7:0]  pal_idx
);

	logic [7:0] ph;
	logic [7:0] i0, i1, i2, i3;
	logic signed [ppg_pkg::SUM_W-1:0] s0, s1, s2, s3, sum, biased;
	logic signed [ppg_pkg::SUM_W-1:0] q;

	assign ph = frame_count[8:1];
	assign i0 = {pixel_y[6:0], 1'b0} - ph - 8'd64;
	assign i1 = {pixel_x[6:0], 1'b0} - ph;
	assign i2 = pixel_y + ph;
	assign i3 = pixel_x[7:0] + ph - 8'd64;

	assign s0 = ppg_pkg::SUM_W'(ppg_pkg::sine_val(i0));
	assign s1 = ppg_pkg::SUM_W'(ppg_pkg::sine_val(i1));
	assign s2 = ppg_pkg::SUM_W'(ppg_pkg::sine_val(i2));
	assign s3 = ppg_pkg::SUM_W'(ppg_pkg::sine_val(i3));

	assign sum = s0 + s1 + s2 + s3;
	// round toward zero
	assign biased = sum + (sum[ppg_pkg::SUM_W-1] ? 10'sd3 : 10'sd0);
	assign q = biased >>> 2;
	assign pal_idx = {~q[7], q[6:0]};

endmodule
